### rtl/core/oaht_pkg.sv
// Shared types and constants of the open-address hash table.
`default_nettype none
package oaht_pkg;

    localparam int MAX_SLOTS   = 1024;
    localparam int START_SLOTS = 4;
    localparam int IDX_W       = $clog2(MAX_SLOTS);
    localparam int CAP_W       = IDX_W + 1;
    localparam int ADDR_W      = IDX_W + 1;
    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_OCC   = 2'd1,
        SLOT_DEL   = 2'd2
    } t_slot_st;

    typedef enum logic [2:0] {
        CMD_SET     = 3'd0,
        CMD_EMPLACE = 3'd1,
        CMD_LOOKUP  = 3'd2,
        CMD_ERASE   = 3'd3,
        CMD_CLEAR   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_INT   = 2'd0,
        KIND_INT64 = 2'd1,
        KIND_BOOL  = 2'd2,
        KIND_BYTE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_NOTFOUND = 2'd1,
        STAT_FULL     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_PRD,
        S_PEV,
        S_GCHK,
        S_RH_RD,
        S_RH_EV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]       st;
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } t_entry;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        t_entry                wdata;
        logic [ADDR_W-1:0]     raddr;
    } t_mem_req;

endpackage
`default_nettype wire

### rtl/core/open_address_hash_table_top.sv
// Top level of the open-address hash table with quadratic probing.
//
// Input channel (i_in_valid / o_in_ready) carries one command item: command,
// key kind, key and value. Output channel (o_out_valid / i_out_ready) returns
// one result item per command: status, key_existed, value_out, entry_count.
// One item is worked at a time; o_in_ready is high only when idle.
// Each probe step is a memory read and then a compare, through one shared
// compare unit. After its probe run, set and a placing insert pass a growth
// check before their result; lookup, erase and an insert that finds its key
// go straight to the result, which shows in the same cycle that the next
// item can be taken. A growing insert adds a clear sweep of the new
// capacity, a read and check of each old slot and a probe run per live
// entry. Clear-all sweeps every slot of the current capacity.
// After reset the first four slots are swept empty before the
// first item is taken. Entries live in two banks of one memory; growth
// rehashes into the other bank and swaps.
// A finished result waits in the output register while the receiver stalls;
// the next item may be accepted meanwhile, but its result waits its turn.
`default_nettype none
module open_address_hash_table_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [2:0]                   i_command,
    input  wire  [1:0]                   i_key_kind,
    input  wire  signed [63:0]           i_key,
    input  wire  [63:0]                  i_value,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [1:0]                   o_status,
    output logic                         o_key_existed,
    output logic [63:0]                  o_value_out,
    output logic [oaht_pkg::CAP_W-1:0]   o_entry_count
);

    localparam int IW = oaht_pkg::IDX_W;
    localparam int CW = oaht_pkg::CAP_W;

    function automatic logic [IW-1:0] home_slot(input logic [63:0] key,
                                               input logic [IW-1:0] mask);
        logic [IW-1:0] lo;
        logic [IW-1:0] sh;
        lo = key[IW-1:0];
        sh = lo << 5;
        return (sh - lo) & mask;
    endfunction

    oaht_pkg::t_state   r_state, n_state;
    logic [2:0]         r_cmd, n_cmd;
    logic [1:0]         r_kind, n_kind;
    logic [63:0]        r_nk, n_nk;
    logic [63:0]        r_val, n_val;
    logic [IW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_k, n_k;
    logic [IW-1:0]      r_sq, n_sq;
    logic [CW-1:0]      r_cap, n_cap;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_sweep, n_sweep;
    logic               r_bank, n_bank;
    logic               r_regrow, n_regrow;
    logic               r_boot, n_boot;
    logic [1:0]         r_status, n_status;
    logic               r_existed, n_existed;
    logic [63:0]        r_vout, n_vout;
    logic               r_ov, n_ov;
    logic [1:0]         r_o_status, n_o_status;
    logic               r_o_existed, n_o_existed;
    logic [63:0]        r_o_vout, n_o_vout;
    logic [CW-1:0]      r_o_count, n_o_count;

    oaht_pkg::t_mem_req mem_req;
    oaht_pkg::t_entry   q;

    logic [IW-1:0]      mask;
    logic               pb;
    logic               in_acc;
    logic [63:0]        in_nk;
    logic               pass_del;
    logic               is_place;
    logic               ev_free;
    logic               ev_match;
    logic               ev_limit;
    logic               rh_last;
    logic               clr_last;
    logic               grow_ok;
    logic               out_fire;

    oaht_mem u_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (q)
    );

    always_comb begin
        mask     = r_cap[IW-1:0] - IW'(1);
        pb       = r_regrow ? ~r_bank : r_bank;
        in_acc   = i_in_valid && o_in_ready;
        pass_del = !r_regrow && (r_cmd == oaht_pkg::CMD_LOOKUP || r_cmd == oaht_pkg::CMD_ERASE);
        is_place = r_regrow || r_cmd == oaht_pkg::CMD_SET || r_cmd == oaht_pkg::CMD_EMPLACE;
        ev_free  = q.st == oaht_pkg::SLOT_EMPTY || (!pass_del && q.st == oaht_pkg::SLOT_DEL);
        ev_match = q.st == oaht_pkg::SLOT_OCC && q.kind == r_kind && q.key == r_nk;
        ev_limit = r_k == r_cap;
        rh_last  = (r_sweep + CW'(1)) == (r_cap >> 1);
        clr_last = r_sweep == (r_cap - CW'(1));
        grow_ok  = ({r_count, 2'b00} == ({2'b00, r_cap} + {1'b0, r_cap, 1'b0}))
                   && ({r_cap, 1'b0} <= (CW+1)'(oaht_pkg::MAX_SLOTS));
        out_fire = !r_ov || i_out_ready;
        unique case (i_key_kind)
            oaht_pkg::KIND_INT:   in_nk = {{32{i_key[31]}}, i_key[31:0]};
            oaht_pkg::KIND_INT64: in_nk = i_key;
            oaht_pkg::KIND_BOOL:  in_nk = {63'd0, |i_key};
            default:              in_nk = {56'd0, i_key[7:0]};
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oaht_pkg::S_CLR: begin
                if (clr_last) begin
                    if (r_regrow)    n_state = oaht_pkg::S_RH_RD;
                    else if (r_boot) n_state = oaht_pkg::S_IDLE;
                    else             n_state = oaht_pkg::S_OUT;
                end
            end
            oaht_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (i_command)
                        oaht_pkg::CMD_SET, oaht_pkg::CMD_EMPLACE,
                        oaht_pkg::CMD_LOOKUP, oaht_pkg::CMD_ERASE: n_state = oaht_pkg::S_PRD;
                        oaht_pkg::CMD_CLEAR: n_state = oaht_pkg::S_CLR;
                        default:             n_state = oaht_pkg::S_OUT;
                    endcase
                end
            end
            oaht_pkg::S_PRD: n_state = oaht_pkg::S_PEV;
            oaht_pkg::S_PEV: begin
                if (ev_free || ev_match || ev_limit) begin
                    if (r_regrow) begin
                        n_state = rh_last ? oaht_pkg::S_OUT : oaht_pkg::S_RH_RD;
                    end else if ((ev_free || ev_match) && is_place
                                 && !(r_cmd == oaht_pkg::CMD_EMPLACE && ev_match)) begin
                        n_state = oaht_pkg::S_GCHK;
                    end else begin
                        n_state = oaht_pkg::S_OUT;
                    end
                end else begin
                    n_state = oaht_pkg::S_PRD;
                end
            end
            oaht_pkg::S_GCHK:  n_state = grow_ok ? oaht_pkg::S_CLR : oaht_pkg::S_OUT;
            oaht_pkg::S_RH_RD: n_state = oaht_pkg::S_RH_EV;
            oaht_pkg::S_RH_EV: begin
                if (q.st == oaht_pkg::SLOT_OCC) n_state = oaht_pkg::S_PRD;
                else if (rh_last)               n_state = oaht_pkg::S_OUT;
                else                            n_state = oaht_pkg::S_RH_RD;
            end
            oaht_pkg::S_OUT: if (out_fire) n_state = oaht_pkg::S_IDLE;
            default: n_state = oaht_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd = r_cmd;  n_kind = r_kind;  n_nk = r_nk;  n_val = r_val;
        n_idx = r_idx;  n_k = r_k;  n_sq = r_sq;  n_cap = r_cap;
        n_count = r_count;  n_sweep = r_sweep;  n_bank = r_bank;
        n_regrow = r_regrow;  n_boot = r_boot;
        n_status = r_status;  n_existed = r_existed;  n_vout = r_vout;
        n_ov = r_ov && !i_out_ready;
        n_o_status = r_o_status;  n_o_existed = r_o_existed;
        n_o_vout = r_o_vout;  n_o_count = r_o_count;
        o_in_ready = r_state == oaht_pkg::S_IDLE;
        mem_req.we    = 1'b0;
        mem_req.waddr = {pb, r_idx};
        mem_req.wdata = '{st: oaht_pkg::SLOT_OCC, kind: r_kind, key: r_nk, val: r_val};
        mem_req.raddr = {pb, r_idx};

        unique case (r_state)
            oaht_pkg::S_CLR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = {pb, r_sweep[IW-1:0]};
                mem_req.wdata.st = oaht_pkg::SLOT_EMPTY;
                n_sweep = r_sweep + CW'(1);
                if (clr_last) begin
                    n_sweep = '0;
                    n_boot  = 1'b0;
                end
            end
            oaht_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_cmd     = i_command;
                    n_kind    = i_key_kind;
                    n_nk      = in_nk;
                    n_val     = i_value;
                    n_idx     = home_slot(in_nk, mask);
                    n_k       = CW'(1);
                    n_sq      = IW'(1);
                    n_status  = oaht_pkg::STAT_OK;
                    n_existed = 1'b0;
                    n_vout    = '0;
                    if (i_command == oaht_pkg::CMD_CLEAR) begin
                        n_count = '0;
                        n_sweep = '0;
                    end
                end
            end
            oaht_pkg::S_PRD: ;
            oaht_pkg::S_PEV: begin
                if (ev_free) begin
                    if (is_place) begin
                        mem_req.we = 1'b1;
                        n_count    = r_count + CW'(1);
                    end else begin
                        n_status = oaht_pkg::STAT_NOTFOUND;
                    end
                end else if (ev_match) begin
                    if (!r_regrow) n_existed = 1'b1;
                    if (r_regrow || r_cmd == oaht_pkg::CMD_SET) begin
                        mem_req.we = 1'b1;
                    end else if (r_cmd == oaht_pkg::CMD_LOOKUP) begin
                        n_vout = q.val;
                    end else if (r_cmd == oaht_pkg::CMD_ERASE) begin
                        mem_req.we    = 1'b1;
                        mem_req.wdata = q;
                        mem_req.wdata.st = oaht_pkg::SLOT_DEL;
                        n_count = r_count - CW'(1);
                    end
                end else if (ev_limit) begin
                    if (!r_regrow) n_status = oaht_pkg::STAT_FULL;
                end else begin
                    n_idx = (r_idx + r_sq) & mask;
                    n_k   = r_k + CW'(1);
                    n_sq  = r_sq + {r_k[IW-2:0], 1'b1};
                end
                if (r_regrow && (ev_free || ev_match || ev_limit)) begin
                    n_sweep = r_sweep + CW'(1);
                    if (rh_last) begin
                        n_bank   = ~r_bank;
                        n_regrow = 1'b0;
                    end
                end
            end
            oaht_pkg::S_GCHK: begin
                if (grow_ok) begin
                    n_cap    = {r_cap[CW-2:0], 1'b0};
                    n_regrow = 1'b1;
                    n_count  = '0;
                    n_sweep  = '0;
                end
            end
            oaht_pkg::S_RH_RD: begin
                mem_req.raddr = {r_bank, r_sweep[IW-1:0]};
            end
            oaht_pkg::S_RH_EV: begin
                if (q.st == oaht_pkg::SLOT_OCC) begin
                    n_kind = q.kind;
                    n_nk   = q.key;
                    n_val  = q.val;
                    n_idx  = home_slot(q.key, mask);
                    n_k    = CW'(1);
                    n_sq   = IW'(1);
                end else begin
                    n_sweep = r_sweep + CW'(1);
                    if (rh_last) begin
                        n_bank   = ~r_bank;
                        n_regrow = 1'b0;
                    end
                end
            end
            oaht_pkg::S_OUT: begin
                if (out_fire) begin
                    n_ov        = 1'b1;
                    n_o_status  = r_status;
                    n_o_existed = r_existed;
                    n_o_vout    = r_vout;
                    n_o_count   = r_count;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= oaht_pkg::S_CLR;
            r_cap    <= CW'(oaht_pkg::START_SLOTS);
            r_count  <= '0;
            r_sweep  <= '0;
            r_bank   <= 1'b0;
            r_regrow <= 1'b0;
            r_boot   <= 1'b1;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cap    <= n_cap;
            r_count  <= n_count;
            r_sweep  <= n_sweep;
            r_bank   <= n_bank;
            r_regrow <= n_regrow;
            r_boot   <= n_boot;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_kind      <= n_kind;
        r_nk        <= n_nk;
        r_val       <= n_val;
        r_idx       <= n_idx;
        r_k         <= n_k;
        r_sq        <= n_sq;
        r_status    <= n_status;
        r_existed   <= n_existed;
        r_vout      <= n_vout;
        r_o_status  <= n_o_status;
        r_o_existed <= n_o_existed;
        r_o_vout    <= n_o_vout;
        r_o_count   <= n_o_count;
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_o_status;
    assign o_key_existed = r_o_existed;
    assign o_value_out   = r_o_vout;
    assign o_entry_count = r_o_count;

endmodule
`default_nettype wire

### rtl/core/oaht_mem.sv
// Slot memory of both table banks, one write and one registered read port.
`default_nettype none
module oaht_mem (
    input  wire                  i_clk,
    input  wire oaht_pkg::t_mem_req i_req,
    output oaht_pkg::t_entry     o_rd_data
);

    oaht_pkg::t_entry r_mem [2**oaht_pkg::ADDR_W];
    oaht_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rd_data <= r_mem[i_req.raddr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### rtl/core/oaht_checker.sv
// Port-level checks of the hash table top level, bound to it.
`default_nettype none
module oaht_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_in_valid,
    input wire                        o_in_ready,
    input wire                        o_out_valid,
    input wire                        i_out_ready,
    input wire [1:0]                  o_status,
    input wire                        o_key_existed,
    input wire [63:0]                 o_value_out,
    input wire [oaht_pkg::CAP_W-1:0]  o_entry_count
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_value_out) && $stable(o_entry_count))
        else $error("result item changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after an accepted item");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status != 2'd3)
        else $error("illegal status code");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_entry_count <= oaht_pkg::CAP_W'(oaht_pkg::MAX_SLOTS))
        else $error("entry count above capacity");

    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_key_existed |-> o_value_out == 64'd0)
        else $error("value on a miss");

endmodule

bind open_address_hash_table_top oaht_checker u_oaht_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_key_existed (o_key_existed),
    .o_value_out   (o_value_out),
    .o_entry_count (o_entry_count)
);
`default_nettype wire
